@@ rtl/kts_pkg.sv @@
// Package for the eased keyframe track sampler.
// Holds request codes, register indexes, state, region and command types.
// No dependencies.
package kts_pkg;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic CFG_KEY_COUNT = 1'b0;
  localparam logic CFG_DEFAULT   = 1'b1;

  localparam int KEY_COUNT_W = 5;
  localparam int VAL_W       = 32;
  localparam int DIV_STEPS   = 16;

  typedef enum logic [2:0] {
    REG_EMPTY  = 3'd0,
    REG_SINGLE = 3'd1,
    REG_BEFORE = 3'd2,
    REG_AFTER  = 3'd3,
    REG_INTERP = 3'd4
  } region_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SEL,
    S_SIMPLE,
    S_CAPB,
    S_CAPA,
    S_DIV,
    S_SQ,
    S_EASE,
    S_VMUL,
    S_VFIN
  } state_t;

  typedef struct packed {
    logic    wr;
    logic    start_q;
    logic    rd_en;
    logic    scan_cmp;
    logic    cap_b;
    logic    cap_a;
    logic    div_step;
    logic    sq;
    logic    ease;
    logic    vmul;
    logic    out_default;
    logic    out_simple;
    logic    out_interp;
    region_t region;
  } cmd_t;

  typedef struct packed {
    logic has_before;
    logic has_after;
  } status_t;

endpackage

@@ rtl/kts_ctrl.sv @@
// Controller of the eased keyframe track sampler.
// Sequences scan, fetch, divide, ease and scale steps; depends on kts_pkg.
module kts_ctrl #(
  parameter int MAX_KEYS = 16,
  parameter int AW       = $clog2(MAX_KEYS)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             req_type,
  input  logic [3:0]                       key_index,
  input  logic [kts_pkg::KEY_COUNT_W-1:0]  key_count,
  input  kts_pkg::status_t                 status,
  input  logic [AW-1:0]                    before_idx,
  input  logic [AW-1:0]                    after_idx,
  output kts_pkg::cmd_t                    cmd,
  output logic [AW-1:0]                    rd_addr,
  output logic                             busy
);
  import kts_pkg::*;

  localparam int CW = $clog2(MAX_KEYS + 1);

  state_t               state_r, state_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [3:0]           div_cnt_r, div_cnt_nxt;
  region_t              region_r, region_nxt;
  logic [CW-1:0]        n;
  logic [AW-1:0]        n_last;
  logic                 accept;

  always_comb begin
    if (32'(key_count) > MAX_KEYS) begin
      n = CW'(MAX_KEYS);
    end else begin
      n = CW'(key_count);
    end
  end

  assign n_last = AW'(n - CW'(1));
  assign accept = start && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= '0;
      div_cnt_r <= '0;
      region_r  <= REG_EMPTY;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      div_cnt_r <= div_cnt_nxt;
      region_r  <= region_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    div_cnt_nxt = div_cnt_r;
    region_nxt  = region_r;
    case (state_r)
      S_IDLE: begin
        if (accept && req_type == REQ_QUERY) begin
          idx_nxt = '0;
          if (n == CW'(1)) begin
            state_nxt = S_SEL;
          end else if (n != '0) begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (idx_r == n_last) begin
          state_nxt = S_SEL;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_SEL: begin
        if (n == CW'(1)) begin
          region_nxt = REG_SINGLE;
          state_nxt  = S_SIMPLE;
        end else if (!status.has_before) begin
          region_nxt = REG_BEFORE;
          state_nxt  = S_SIMPLE;
        end else if (!status.has_after) begin
          region_nxt = REG_AFTER;
          state_nxt  = S_SIMPLE;
        end else begin
          region_nxt = REG_INTERP;
          state_nxt  = S_CAPB;
        end
      end
      S_SIMPLE: state_nxt = S_IDLE;
      S_CAPB:   state_nxt = S_CAPA;
      S_CAPA: begin
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        div_cnt_nxt = div_cnt_r + 4'd1;
        if (div_cnt_r == 4'(DIV_STEPS - 1)) begin
          state_nxt = S_SQ;
        end
      end
      S_SQ:   state_nxt = S_EASE;
      S_EASE: state_nxt = S_VMUL;
      S_VMUL: state_nxt = S_VFIN;
      S_VFIN: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.region = region_r;
    rd_addr    = idx_r;
    busy       = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (accept && req_type == REQ_WRITE) begin
          cmd.wr = (32'(key_index) < MAX_KEYS);
        end
        if (accept && req_type == REQ_QUERY) begin
          cmd.start_q = 1'b1;
          if (n == '0) begin
            cmd.out_default = 1'b1;
            cmd.region      = REG_EMPTY;
          end
        end
      end
      S_SCAN_RD: cmd.rd_en = 1'b1;
      S_SCAN_CMP: cmd.scan_cmp = 1'b1;
      S_SEL: begin
        cmd.rd_en = 1'b1;
        if (n == CW'(1) || !status.has_before) begin
          rd_addr = '0;
        end else if (!status.has_after) begin
          rd_addr = n_last;
        end else begin
          rd_addr = before_idx;
        end
      end
      S_SIMPLE: cmd.out_simple = 1'b1;
      S_CAPB: begin
        cmd.cap_b = 1'b1;
        cmd.rd_en = 1'b1;
        rd_addr   = after_idx;
      end
      S_CAPA: cmd.cap_a = 1'b1;
      S_DIV:  cmd.div_step = 1'b1;
      S_SQ:   cmd.sq = 1'b1;
      S_EASE: cmd.ease = 1'b1;
      S_VMUL: cmd.vmul = 1'b1;
      S_VFIN: cmd.out_interp = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/kts_dp.sv @@
// Datapath of the eased keyframe track sampler.
// Keyframe memories, scan flags, serial divider, easing and scaling; depends on kts_pkg.
module kts_dp #(
  parameter int MAX_KEYS = 16,
  parameter int AW       = $clog2(MAX_KEYS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kts_pkg::cmd_t               cmd,
  input  logic [AW-1:0]               rd_addr,
  input  logic [3:0]                  wr_index,
  input  logic [31:0]                 wr_time,
  input  logic signed [31:0]          wr_value,
  input  logic [31:0]                 query_time,
  input  logic signed [31:0]          default_value,
  output kts_pkg::status_t            status,
  output logic [AW-1:0]               before_idx,
  output logic [AW-1:0]               after_idx,
  output logic                        out_strobe,
  output logic signed [31:0]          out_sample_value,
  output logic [2:0]                  out_region
);
  import kts_pkg::*;

  logic [31:0]        time_mem [MAX_KEYS];
  logic [31:0]        value_mem [MAX_KEYS];
  logic [31:0]        rd_time_r;
  logic signed [31:0] rd_value_r;
  logic [AW-1:0]      rd_addr_q_r;
  logic [31:0]        q_r;
  logic               has_before_r, has_after_r;
  logic [AW-1:0]      before_r, after_r;
  logic [31:0]        t0_r, span_r, rem_r;
  logic signed [31:0] v0_r;
  logic signed [32:0] diff_r;
  logic [15:0]        quot_r;
  logic [16:0]        mx;
  logic [33:0]        sq_r;
  logic [16:0]        e_r, e_nxt;
  logic signed [50:0] prod_r;
  logic signed [50:0] sum;
  logic [32:0]        rem2, rem_diff;
  logic               strobe_r;
  logic signed [31:0] res_r;
  region_t            region_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      time_mem[AW'(wr_index)]  <= wr_time;
      value_mem[AW'(wr_index)] <= wr_value;
    end
    if (cmd.rd_en) begin
      rd_time_r   <= time_mem[rd_addr];
      rd_value_r  <= value_mem[rd_addr];
      rd_addr_q_r <= rd_addr;
    end
  end

  assign rem2     = {rem_r, 1'b0};
  assign rem_diff = rem2 - {1'b0, span_r};

  always_comb begin
    if (!quot_r[15]) begin
      mx = {1'b0, quot_r};
    end else begin
      mx = 17'(18'h20000 - {1'b0, quot_r, 1'b0});
    end
  end

  always_comb begin
    if (!quot_r[15]) begin
      e_nxt = 17'(sq_r >> 15);
    end else begin
      e_nxt = 17'h10000 - 17'(sq_r >> 17);
    end
  end

  assign sum = 51'(v0_r) + (prod_r >>> 16);

  always_ff @(posedge clk) begin
    if (cmd.start_q) begin
      q_r <= query_time;
    end
    if (cmd.scan_cmp) begin
      if (rd_time_r <= q_r) begin
        before_r <= rd_addr_q_r;
      end
      if (rd_time_r > q_r && !has_after_r) begin
        after_r <= rd_addr_q_r;
      end
    end
    if (cmd.cap_b) begin
      t0_r <= rd_time_r;
      v0_r <= rd_value_r;
    end
    if (cmd.cap_a) begin
      span_r <= rd_time_r - t0_r;
      rem_r  <= q_r - t0_r;
      diff_r <= 33'(rd_value_r) - 33'(v0_r);
    end
    if (cmd.div_step) begin
      if (!rem_diff[32]) begin
        rem_r  <= rem_diff[31:0];
        quot_r <= {quot_r[14:0], 1'b1};
      end else begin
        rem_r  <= rem2[31:0];
        quot_r <= {quot_r[14:0], 1'b0};
      end
    end
    if (cmd.sq) begin
      sq_r <= 34'(mx) * 34'(mx);
    end
    if (cmd.ease) begin
      e_r <= e_nxt;
    end
    if (cmd.vmul) begin
      prod_r <= diff_r * $signed({1'b0, e_r});
    end
    if (cmd.out_default) begin
      res_r <= default_value;
    end else if (cmd.out_simple) begin
      res_r <= rd_value_r;
    end else if (cmd.out_interp) begin
      res_r <= sum[31:0];
    end
    if (cmd.out_default || cmd.out_simple || cmd.out_interp) begin
      region_r <= cmd.region;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_before_r <= 1'b0;
      has_after_r  <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      strobe_r <= cmd.out_default || cmd.out_simple || cmd.out_interp;
      if (cmd.start_q) begin
        has_before_r <= 1'b0;
        has_after_r  <= 1'b0;
      end else if (cmd.scan_cmp) begin
        if (rd_time_r <= q_r) begin
          has_before_r <= 1'b1;
        end else begin
          has_after_r <= 1'b1;
        end
      end
    end
  end

  assign status.has_before = has_before_r;
  assign status.has_after  = has_after_r;
  assign before_idx        = before_r;
  assign after_idx         = after_r;
  assign out_strobe        = strobe_r;
  assign out_sample_value  = res_r;
  assign out_region        = region_r;

endmodule

@@ rtl/keyframe_track_eased_sampler.sv @@
// Top level of the eased keyframe track sampler: configuration registers,
// controller and datapath. Depends on kts_pkg, kts_ctrl and kts_dp.
//
//   channel  handshake          payload
//   in       start, busy        in_req_type, in_key_index, in_key_time,
//                               in_key_value, in_query_time
//   out      out_strobe         out_sample_value, out_region
//   cfg      cfg_we             cfg_index, cfg_data
//
// A keyframe write leaves busy low.
// An empty-track query answers at once with the default value; a single-key query
// reads key 0. Other queries scan the n keyframes one by one over the single read
// port of the keyframe memory; interpolating queries then fetch both bracketing keys
// and run the 16-step divider, squaring, easing and scaling.
// The result strobe comes in the cycle after the last step; it cannot be stalled.
// Synchronous reset clears control state and the configuration registers.
module keyframe_track_eased_sampler #(
  parameter int MAX_KEYS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [3:0]         in_key_index,
  input  logic [31:0]        in_key_time,
  input  logic signed [31:0] in_key_value,
  input  logic [31:0]        in_query_time,
  output logic               out_strobe,
  output logic signed [31:0] out_sample_value,
  output logic [2:0]         out_region,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import kts_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);

  logic [KEY_COUNT_W-1:0] key_count_r;
  logic signed [31:0]     default_value_r;
  cmd_t                   cmd;
  status_t                status;
  logic [AW-1:0]          rd_addr, before_idx, after_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r     <= '0;
      default_value_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_COUNT: key_count_r     <= cfg_data[KEY_COUNT_W-1:0];
        CFG_DEFAULT:   default_value_r <= cfg_data;
        default:       key_count_r     <= key_count_r;
      endcase
    end
  end

  kts_ctrl #(.MAX_KEYS(MAX_KEYS), .AW(AW)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req_type   (in_req_type),
    .key_index  (in_key_index),
    .key_count  (key_count_r),
    .status     (status),
    .before_idx (before_idx),
    .after_idx  (after_idx),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .busy       (busy)
  );

  kts_dp #(.MAX_KEYS(MAX_KEYS), .AW(AW)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .rd_addr          (rd_addr),
    .wr_index         (in_key_index),
    .wr_time          (in_key_time),
    .wr_value         (in_key_value),
    .query_time       (in_query_time),
    .default_value    (default_value_r),
    .status           (status),
    .before_idx       (before_idx),
    .after_idx        (after_idx),
    .out_strobe       (out_strobe),
    .out_sample_value (out_sample_value),
    .out_region       (out_region)
  );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for keyframe_track_eased_sampler: loads keyframe tables,
// queries them and checks every sample against an in-bench eased interpolation model.
// Depends on kts_pkg and the sampler RTL.
module testbench;
  import kts_pkg::*;

  typedef struct {
    logic signed [31:0] value;
    region_t            rgn;
  } sample_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_req_type;
  logic [3:0]         in_key_index;
  logic [31:0]        in_key_time;
  logic signed [31:0] in_key_value;
  logic [31:0]        in_query_time;
  logic               out_strobe;
  logic signed [31:0] out_sample_value;
  logic [2:0]         out_region;
  logic               cfg_we;
  logic               cfg_index;
  logic [31:0]        cfg_data;

  logic [31:0]        track_times [16];
  logic signed [31:0] track_values [16];
  logic [4:0]         track_count;
  logic signed [31:0] track_default;
  sample_t            pending_samples [$];
  int                 errors;

  keyframe_track_eased_sampler u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_key_index(in_key_index), .in_key_time(in_key_time),
    .in_key_value(in_key_value), .in_query_time(in_query_time),
    .out_strobe(out_strobe), .out_sample_value(out_sample_value), .out_region(out_region),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic longint unsigned ease_quad(longint unsigned p);
    longint unsigned d;
    if (p < 32768) begin
      return (p * p) >> 15;
    end
    d = 131072 - 2 * p;
    return 65536 - ((d * d) >> 17);
  endfunction

  function automatic sample_t sample_track(logic [31:0] q);
    sample_t        s;
    int             n;
    int             lo;
    int             hi;
    longint         v0;
    longint         v1;
    longint unsigned span;
    longint unsigned p;
    lo = -1;
    hi = -1;
    n = (track_count > 16) ? 16 : int'(track_count);
    if (n == 0) begin
      s.value = track_default;
      s.rgn = REG_EMPTY;
    end else if (n == 1) begin
      s.value = track_values[0];
      s.rgn = REG_SINGLE;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (track_times[i] <= q) lo = i;
        if (track_times[i] > q && hi < 0) hi = i;
      end
      if (lo < 0) begin
        s.value = track_values[0];
        s.rgn = REG_BEFORE;
      end else if (hi < 0) begin
        s.value = track_values[n-1];
        s.rgn = REG_AFTER;
      end else begin
        span = longint'(track_times[hi]) - longint'(track_times[lo]);
        p = ((longint'(q) - longint'(track_times[lo])) << 16) / span;
        v0 = track_values[lo];
        v1 = track_values[hi];
        s.value = 32'(v0 + (((v1 - v0) * longint'(ease_quad(p))) >>> 16));
        s.rgn = REG_INTERP;
      end
    end
    return s;
  endfunction

  always @(posedge clk) begin
    sample_t e;
    if (rst_n && out_strobe) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample value=%h region=%0d", $time,
                 out_sample_value, out_region);
        errors++;
      end else begin
        e = pending_samples.pop_front();
        if (out_sample_value !== e.value) begin
          $display("%0t: sample_value expected %h actual %h", $time, e.value,
                   out_sample_value);
          errors++;
        end
        if (out_region !== e.rgn) begin
          $display("%0t: region expected %0d actual %0d", $time, e.rgn, out_region);
          errors++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic req, logic [3:0] idx, logic [31:0] kt, logic [31:0] kv,
                           logic [31:0] qt);
    int gap;
    start <= 1'b1;
    in_req_type <= req;
    in_key_index <= idx;
    in_key_time <= kt;
    in_key_value <= kv;
    in_query_time <= qt;
    do @(posedge clk); while (busy);
    if (req == REQ_WRITE) begin
      track_times[idx] = kt;
      track_values[idx] = kv;
    end else begin
      pending_samples.push_back(sample_track(qt));
    end
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic query(logic [31:0] qt);
    send_item(REQ_QUERY, 4'($urandom), $urandom, $urandom, qt);
  endtask

  task automatic write_key(logic [3:0] idx, logic [31:0] kt, logic [31:0] kv);
    send_item(REQ_WRITE, idx, kt, kv, $urandom);
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    start <= 1'b0;
    while ((pending_samples.size() != 0 || busy) && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_KEY_COUNT) track_count = data[4:0];
    else track_default = data;
  endtask

  task automatic load_track(logic [31:0] t [16], logic [31:0] v [16]);
    for (int i = 0; i < 16; i++) write_key(4'(i), t[i], v[i]);
  endtask

  task automatic test_empty_track();
    write_reg(CFG_DEFAULT, 32'h8000_0000);
    query(32'h0);
    query(32'hFFFF_FFFF);
    write_reg(CFG_DEFAULT, 32'h7FFF_FFFF);
    query($urandom);
  endtask

  task automatic test_single_key();
    logic [31:0] t [16];
    logic [31:0] v [16];
    for (int i = 0; i < 16; i++) begin
      t[i] = 1000 * (i + 1);
      v[i] = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end
    load_track(t, v);
    write_reg(CFG_KEY_COUNT, 1);
    query(0);
    query(32'hFFFF_FFFF);
  endtask

  task automatic test_edges_and_ease();
    write_reg(CFG_KEY_COUNT, 16);
    query(0);
    query(999);
    query(1000);
    query(1500);
    query(1499);
    query(1750);
    query(1999);
    query(16000);
    query(32'hFFFF_FFFF);
    write_reg(CFG_KEY_COUNT, 31);
    query(2500);
    query(16001);
    write_reg(CFG_KEY_COUNT, 2);
    query(1250);
    query(2000);
  endtask

  task automatic test_random_tracks(int total);
    logic [31:0] t [16];
    logic [31:0] v [16];
    int          done;
    int          k;
    int          n;
    logic [31:0] q;
    done = 0;
    while (done < total) begin
      k = $urandom_range(0, 9);
      for (int i = 0; i < 16; i++) begin
        t[i] = (k < 3) ? $urandom : $urandom_range(0, 5000);
        v[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) - 128 : $urandom;
      end
      if (k != 9) t.sort();
      load_track(t, v);
      done += 16;
      case ($urandom_range(0, 7))
        0: n = 0;
        1: n = 1;
        2: n = 2;
        3: n = 16;
        4: n = $urandom_range(17, 31);
        default: n = $urandom_range(2, 16);
      endcase
      write_reg(CFG_KEY_COUNT, n);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_DEFAULT, $urandom);
      repeat ($urandom_range(10, 30)) begin
        k = $urandom_range(0, 15);
        case ($urandom_range(0, 9))
          0: q = t[k];
          1: q = t[k] - 1;
          2: q = t[k] + 1;
          3: q = $urandom;
          4: q = ($urandom_range(0, 1)) ? 32'h0 : 32'hFFFF_FFFF;
          default: begin
            k = $urandom_range(0, 14);
            q = t[k] + 32'((longint'($urandom) * (longint'(t[k+1]) - longint'(t[k])))
                           >> 32);
          end
        endcase
        query(q);
        done++;
        if ($urandom_range(0, 19) == 0) begin
          k = $urandom_range(0, 15);
          write_key(4'(k), t[k], $urandom);
          v[k] = track_values[k];
          done++;
        end
      end
    end
  endtask

  initial begin
    int guard;
    errors = 0;
    track_count = 0;
    track_default = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_req_type <= REQ_WRITE;
    in_key_index <= '0;
    in_key_time <= '0;
    in_key_value <= '0;
    in_query_time <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_KEY_COUNT;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    query(32'h1234_5678);
    test_empty_track();
    test_single_key();
    test_edges_and_ease();
    test_random_tracks(620);
    start <= 1'b0;
    guard = 0;
    while (pending_samples.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
    if (errors == 0 && pending_samples.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      if (pending_samples.size() != 0)
        $display("%0t: %0d samples never arrived", $time, pending_samples.size());
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
